FILE: hw/rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// PSG package
// Shared constants, codes, types and the volume table of the PSG generator.
// ----------------------------------------------------------------------------
package psg_pkg;

    localparam int NUM_CHIPS = 2;
    localparam int NCH       = 3 * NUM_CHIPS;
    localparam int NREG      = 16 * NUM_CHIPS;
    localparam int CHIP_W    = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
    localparam int CH_W      = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int RF_W      = CHIP_W + 4;
    localparam int SUM_W     = $clog2(NCH * 255 + 1);
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 5;

    // The channel average is a multiply by a rounded-up reciprocal of NCH.
    localparam int AVG_SHIFT = 20;
    localparam int AVG_W     = SUM_W + AVG_SHIFT + 1;
    localparam logic [AVG_SHIFT:0] AVG_RECIP =
        (AVG_SHIFT + 1)'(((2 ** AVG_SHIFT) + NCH - 1) / NCH);

    localparam logic [31:0] TIME_BASE = 32'd100000000;
    localparam logic [31:0] ENV_IDLE  = 32'h7fff_fffe;
    localparam logic [31:0] IV_IDLE   = 32'hffff_ffff;
    localparam logic [16:0] LFSR_SEED = 17'd12345;

    localparam logic [15:0] STEP_RESET      = 16'd2267;
    localparam logic [21:0] CLK_FAST_RESET  = 22'd2000000;
    localparam logic [21:0] CLK_SLOW_RESET  = 22'd1789772;

    localparam logic [1:0] CFG_SAMPLE_STEP = 2'd0;
    localparam logic [1:0] CFG_CLOCK_FAST  = 2'd1;
    localparam logic [1:0] CFG_CLOCK_SLOW  = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [3:0] REG_TONE_A_LO  = 4'd0;
    localparam logic [3:0] REG_TONE_C_HI  = 4'd5;
    localparam logic [3:0] REG_NOISE      = 4'd6;
    localparam logic [3:0] REG_MIXER      = 4'd7;
    localparam logic [3:0] REG_ENV_LO     = 4'd11;
    localparam logic [3:0] REG_ENV_HI     = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;
    localparam logic [3:0] REG_SOFT_RESET = 4'd15;

    localparam logic [3:0] SHAPE_DOWN_REPEAT    = 4'd8;
    localparam logic [3:0] SHAPE_TRI_DOWN       = 4'd10;
    localparam logic [3:0] SHAPE_DOWN_HOLD_HIGH = 4'd11;
    localparam logic [3:0] SHAPE_UP_REPEAT      = 4'd12;
    localparam logic [3:0] SHAPE_UP_HOLD_HIGH   = 4'd13;
    localparam logic [3:0] SHAPE_TRI_UP         = 4'd14;

    typedef enum logic [1:0] {
        PER_TONE,
        PER_NOISE,
        PER_ENV
    } period_kind_t;

    typedef enum logic [1:0] {
        ENV_KEEP,
        ENV_ADD,
        ENV_SUB32,
        ENV_SUB64
    } env_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WR_REG,
        ST_WR_PLO,
        ST_WR_PHI,
        ST_WR_DIV1_START,
        ST_WR_DIV1_WAIT,
        ST_WR_DIV2_START,
        ST_WR_DIV2_WAIT,
        ST_TK_NOISE_ADD,
        ST_TK_NOISE_SUB,
        ST_TK_ENV_START,
        ST_TK_ENV_WAIT,
        ST_TK_ENV_APPLY,
        ST_TK_TONE_ADD,
        ST_TK_TONE_CMP,
        ST_TK_MIX,
        ST_TK_OUT
    } psg_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [7:0] vol_lookup(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:  v = 8'h00;  5'd1:  v = 8'h00;  5'd2:  v = 8'h01;  5'd3:  v = 8'h01;
            5'd4:  v = 8'h02;  5'd5:  v = 8'h02;  5'd6:  v = 8'h03;  5'd7:  v = 8'h04;
            5'd8:  v = 8'h05;  5'd9:  v = 8'h06;  5'd10: v = 8'h07;  5'd11: v = 8'h08;
            5'd12: v = 8'h09;  5'd13: v = 8'h0b;  5'd14: v = 8'h0d;  5'd15: v = 8'h10;
            5'd16: v = 8'h13;  5'd17: v = 8'h17;  5'd18: v = 8'h1b;  5'd19: v = 8'h20;
            5'd20: v = 8'h26;  5'd21: v = 8'h2d;  5'd22: v = 8'h36;  5'd23: v = 8'h40;
            5'd24: v = 8'h4c;  5'd25: v = 8'h5a;  5'd26: v = 8'h6b;  5'd27: v = 8'h80;
            5'd28: v = 8'h98;  5'd29: v = 8'hb4;  5'd30: v = 8'hd6;  default: v = 8'hff;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/psg_div.sv
// ----------------------------------------------------------------------------
// PSG divider
// Shared 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psg_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  psg_pkg::div_req_t  req,
    output psg_pkg::div_rsp_t  rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [psg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [psg_pkg::DIV_W-1:0]     quo_reg;
    logic [psg_pkg::DIV_W-1:0]     rem_reg;
    logic [psg_pkg::DIV_W-1:0]     dsr_reg;

    logic [psg_pkg::DIV_W:0]       rem_shift;
    logic [psg_pkg::DIV_W:0]       diff;
    logic [psg_pkg::DIV_W-1:0]     rem_next;
    logic [psg_pkg::DIV_W-1:0]     quo_next;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[psg_pkg::DIV_W-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        if (!diff[psg_pkg::DIV_W]) begin
            rem_next = diff[psg_pkg::DIV_W-1:0];
            quo_next = {quo_reg[psg_pkg::DIV_W-2:0], 1'b1};
        end else begin
            rem_next = rem_shift[psg_pkg::DIV_W-1:0];
            quo_next = {quo_reg[psg_pkg::DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: hw/rtl/psg_sound_generator.sv
// ----------------------------------------------------------------------------
// PSG sound generator
// Two emulated programmable sound chips with register file, tone, noise,
// envelope and mixer, run by a sequencer around one shared divider.
//
// The block takes one word at a time and is not ready while it works on it.
// A period register write also reads its period bytes (one byte for the noise
// period) and runs two divisions on the shared radix-2 divider; the second
// division is skipped when the frequency rounds to zero. A sample tick runs
// two steps per noise generator, an envelope step per chip around one
// division, two steps per tone channel, one mixer step per channel and one
// output step, where the channel average is formed by a multiply with a
// reciprocal. The result word waits in an output register, so the next word
// can be taken while it is still pending; a tick that finishes while that
// word is still waiting holds in its output step until the word is taken.
// ----------------------------------------------------------------------------
module psg_sound_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_reg_address,
    input  logic [7:0]  s_reg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_level,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [21:0] cfg_data
);

    psg_pkg::psg_state_t   state_reg, state_next;
    psg_pkg::period_kind_t kind_reg;
    psg_pkg::div_req_t     div_req;
    psg_pkg::div_rsp_t     div_rsp;

    logic [15:0] step_reg;
    logic [21:0] clk_fast_reg;
    logic [21:0] clk_slow_reg;

    logic [7:0]  reg_file_reg  [psg_pkg::NREG];
    logic [31:0] tone_int_reg  [psg_pkg::NCH];
    logic [31:0] tone_cnt_reg  [psg_pkg::NCH];
    logic        tone_en_reg   [psg_pkg::NCH];
    logic        noise_en_reg  [psg_pkg::NCH];
    logic        tone_out_reg  [psg_pkg::NCH];
    logic [31:0] noise_int_reg [psg_pkg::NUM_CHIPS];
    logic [31:0] noise_cnt_reg [psg_pkg::NUM_CHIPS];
    logic [16:0] lfsr_reg      [psg_pkg::NUM_CHIPS];
    logic        noise_bit_reg [psg_pkg::NUM_CHIPS];
    logic [31:0] env_int_reg   [psg_pkg::NUM_CHIPS];
    logic [31:0] env_cnt_reg   [psg_pkg::NUM_CHIPS];
    logic [4:0]  env_lvl_reg   [psg_pkg::NUM_CHIPS];
    logic        clk_sel_reg;

    logic                      op_reg;
    logic [7:0]                addr_reg;
    logic [7:0]                data_reg;
    logic [15:0]               p_reg;
    logic [31:0]               f_reg;
    logic [31:0]               acc_reg;
    logic [3:0]                mode_reg;
    logic [psg_pkg::SUM_W-1:0] sum_reg;
    logic [psg_pkg::CHIP_W-1:0] chip_reg;
    logic [psg_pkg::CH_W-1:0]  ch_reg;
    logic [1:0]                t_reg;
    logic                      m_valid_reg, m_valid_next;
    logic [7:0]                m_level_reg;

    logic [psg_pkg::CHIP_W-1:0] chip;
    logic [3:0]                 reg_idx;
    logic                       chip_ok;
    logic [psg_pkg::CH_W-1:0]   wr_base;
    logic [psg_pkg::CH_W-1:0]   wr_ch;
    logic [21:0]                cur_clk;
    logic [15:0]                p_eff;
    logic [31:0]                div_f;
    logic [psg_pkg::RF_W-1:0]   rf_raddr;
    logic [7:0]                 rf_rdata;
    logic                       out_load;
    logic                       last_chip;
    logic                       last_ch;
    logic [psg_pkg::AVG_W-1:0]  avg_prod;
    logic [psg_pkg::SUM_W-1:0]  avg_q;

    logic [32:0]       sub_diff;
    logic              sub_gt;
    logic [31:0]       env_iv;
    logic [31:0]       env_q;
    logic              q_lt32;
    logic              q_lt64;
    logic [4:0]        env_v;
    psg_pkg::env_op_t  env_op;
    logic [31:0]       env_cnt_new;
    logic [7:0]        mix_vol;
    logic              sounding;

    assign chip     = addr_reg[4 +: psg_pkg::CHIP_W];
    assign reg_idx  = addr_reg[3:0];
    assign chip_ok  = addr_reg[7:4] < 4'(psg_pkg::NUM_CHIPS);
    assign wr_base  = psg_pkg::CH_W'(int'(chip) * 3);
    assign wr_ch    = wr_base + psg_pkg::CH_W'(reg_idx[3:1]);
    assign cur_clk  = clk_sel_reg ? clk_fast_reg : clk_slow_reg;
    assign p_eff    = (p_reg == '0) ? 16'd1 : p_reg;
    assign div_f    = (kind_reg == psg_pkg::PER_ENV) ? div_rsp.quotient
                                                     : (div_rsp.quotient >> 4);
    assign rf_rdata = reg_file_reg[rf_raddr];
    assign last_chip = chip_reg == psg_pkg::CHIP_W'(psg_pkg::NUM_CHIPS - 1);
    assign last_ch   = ch_reg == psg_pkg::CH_W'(psg_pkg::NCH - 1);
    assign cfg_ready = 1'b1;
    assign avg_prod  = psg_pkg::AVG_W'(sum_reg) * psg_pkg::AVG_W'(psg_pkg::AVG_RECIP);
    assign avg_q     = avg_prod[psg_pkg::AVG_SHIFT +: psg_pkg::SUM_W];

    psg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Shared subtract for the noise and tone wrap tests.
    always_comb begin
        if (state_reg == psg_pkg::ST_TK_NOISE_SUB) begin
            sub_diff = {1'b0, acc_reg} - {1'b0, noise_int_reg[chip_reg]};
        end else begin
            sub_diff = {1'b0, acc_reg} - {1'b0, tone_int_reg[ch_reg]};
        end
        sub_gt = !sub_diff[32] && (sub_diff[31:0] != '0);
    end

    always_comb begin
        env_iv = (env_int_reg[chip_reg] == '0) ? 32'd1 : env_int_reg[chip_reg];
        env_q  = div_rsp.quotient;
        q_lt32 = env_q[31:5] == '0;
        q_lt64 = env_q[31:6] == '0;
        env_v  = '0;
        env_op = psg_pkg::ENV_KEEP;
        if (q_lt32) begin
            env_op = psg_pkg::ENV_ADD;
            env_v  = (mode_reg[2] == 1'b0) ? ~env_q[4:0] : env_q[4:0];
        end else begin
            case (mode_reg) inside
                psg_pkg::SHAPE_DOWN_REPEAT: begin
                    env_op = psg_pkg::ENV_SUB32;
                    env_v  = 5'd31;
                end
                psg_pkg::SHAPE_UP_REPEAT: begin
                    env_op = psg_pkg::ENV_SUB32;
                end
                psg_pkg::SHAPE_DOWN_HOLD_HIGH, psg_pkg::SHAPE_UP_HOLD_HIGH: begin
                    env_v = 5'd31;
                end
                psg_pkg::SHAPE_TRI_DOWN, psg_pkg::SHAPE_TRI_UP: begin
                    if (q_lt64) begin
                        env_op = psg_pkg::ENV_ADD;
                        env_v  = (mode_reg == psg_pkg::SHAPE_TRI_DOWN) ? env_q[4:0]
                                                                       : ~env_q[4:0];
                    end else begin
                        env_op = psg_pkg::ENV_SUB64;
                        env_v  = (mode_reg == psg_pkg::SHAPE_TRI_DOWN) ? 5'd31 : 5'd0;
                    end
                end
                default: begin
                    env_v = '0;
                end
            endcase
        end
        case (env_op)
            psg_pkg::ENV_ADD:   env_cnt_new = env_cnt_reg[chip_reg] + 32'(step_reg);
            psg_pkg::ENV_SUB32: env_cnt_new = env_cnt_reg[chip_reg] - {env_iv[26:0], 5'b0};
            psg_pkg::ENV_SUB64: env_cnt_new = env_cnt_reg[chip_reg] - {env_iv[25:0], 6'b0};
            default:            env_cnt_new = env_cnt_reg[chip_reg];
        endcase
    end

    always_comb begin
        sounding = tone_out_reg[ch_reg] | (noise_bit_reg[chip_reg] & noise_en_reg[ch_reg]);
        if (!sounding) begin
            mix_vol = '0;
        end else if (rf_rdata[4]) begin
            mix_vol = psg_pkg::vol_lookup(env_lvl_reg[chip_reg]);
        end else begin
            mix_vol = psg_pkg::vol_lookup({rf_rdata[3:0], 1'b1});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= psg_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        s_ready          = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        rf_raddr         = '0;
        unique case (state_reg)
            psg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = (s_operation == psg_pkg::OP_TICK) ?
                                 psg_pkg::ST_TK_NOISE_ADD : psg_pkg::ST_WR_REG;
                end
            end
            psg_pkg::ST_WR_REG: begin
                state_next = psg_pkg::ST_IDLE;
                if (chip_ok) begin
                    case (reg_idx) inside
                        [psg_pkg::REG_TONE_A_LO:psg_pkg::REG_TONE_C_HI],
                        psg_pkg::REG_NOISE, psg_pkg::REG_ENV_LO, psg_pkg::REG_ENV_HI:
                            state_next = psg_pkg::ST_WR_PLO;
                        default: state_next = psg_pkg::ST_IDLE;
                    endcase
                end
            end
            psg_pkg::ST_WR_PLO: begin
                unique case (kind_reg)
                    psg_pkg::PER_TONE:  rf_raddr = {chip, reg_idx[3:1], 1'b0};
                    psg_pkg::PER_NOISE: rf_raddr = {chip, psg_pkg::REG_NOISE};
                    default:            rf_raddr = {chip, psg_pkg::REG_ENV_LO};
                endcase
                state_next = (kind_reg == psg_pkg::PER_NOISE) ?
                             psg_pkg::ST_WR_DIV1_START : psg_pkg::ST_WR_PHI;
            end
            psg_pkg::ST_WR_PHI: begin
                rf_raddr   = (kind_reg == psg_pkg::PER_TONE) ? {chip, reg_idx[3:1], 1'b1}
                                                             : {chip, psg_pkg::REG_ENV_HI};
                state_next = psg_pkg::ST_WR_DIV1_START;
            end
            psg_pkg::ST_WR_DIV1_START: begin
                div_req.start    = 1'b1;
                div_req.dividend = 32'(cur_clk);
                div_req.divisor  = 32'(p_eff);
                state_next       = psg_pkg::ST_WR_DIV1_WAIT;
            end
            psg_pkg::ST_WR_DIV1_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (div_f == '0) ? psg_pkg::ST_IDLE : psg_pkg::ST_WR_DIV2_START;
                end
            end
            psg_pkg::ST_WR_DIV2_START: begin
                div_req.start    = 1'b1;
                div_req.dividend = psg_pkg::TIME_BASE;
                div_req.divisor  = f_reg;
                state_next       = psg_pkg::ST_WR_DIV2_WAIT;
            end
            psg_pkg::ST_WR_DIV2_WAIT: begin
                if (div_rsp.done) begin
                    state_next = psg_pkg::ST_IDLE;
                end
            end
            psg_pkg::ST_TK_NOISE_ADD: begin
                state_next = psg_pkg::ST_TK_NOISE_SUB;
            end
            psg_pkg::ST_TK_NOISE_SUB: begin
                state_next = last_chip ? psg_pkg::ST_TK_ENV_START : psg_pkg::ST_TK_NOISE_ADD;
            end
            psg_pkg::ST_TK_ENV_START: begin
                rf_raddr         = {chip_reg, psg_pkg::REG_ENV_SHAPE};
                div_req.start    = 1'b1;
                div_req.dividend = env_cnt_reg[chip_reg];
                div_req.divisor  = env_iv;
                state_next       = psg_pkg::ST_TK_ENV_WAIT;
            end
            psg_pkg::ST_TK_ENV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = psg_pkg::ST_TK_ENV_APPLY;
                end
            end
            psg_pkg::ST_TK_ENV_APPLY: begin
                state_next = last_chip ? psg_pkg::ST_TK_TONE_ADD : psg_pkg::ST_TK_ENV_START;
            end
            psg_pkg::ST_TK_TONE_ADD: begin
                state_next = psg_pkg::ST_TK_TONE_CMP;
            end
            psg_pkg::ST_TK_TONE_CMP: begin
                state_next = last_ch ? psg_pkg::ST_TK_MIX : psg_pkg::ST_TK_TONE_ADD;
            end
            psg_pkg::ST_TK_MIX: begin
                rf_raddr   = {chip_reg, 2'b10, t_reg};
                state_next = last_ch ? psg_pkg::ST_TK_OUT : psg_pkg::ST_TK_MIX;
            end
            psg_pkg::ST_TK_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = psg_pkg::ST_IDLE;
                end
            end
            default: state_next = psg_pkg::ST_IDLE;
        endcase
        m_valid_next = out_load | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_level_reg <= (avg_q > psg_pkg::SUM_W'(255)) ? 8'hff : avg_q[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= psg_pkg::STEP_RESET;
            clk_fast_reg <= psg_pkg::CLK_FAST_RESET;
            clk_slow_reg <= psg_pkg::CLK_SLOW_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                psg_pkg::CFG_SAMPLE_STEP: step_reg     <= cfg_data[15:0];
                psg_pkg::CFG_CLOCK_FAST:  clk_fast_reg <= cfg_data;
                psg_pkg::CFG_CLOCK_SLOW:  clk_slow_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < psg_pkg::NREG; i++) begin
                reg_file_reg[i] <= (4'(i) == psg_pkg::REG_MIXER) ? 8'hff : 8'h00;
            end
            for (int i = 0; i < psg_pkg::NCH; i++) begin
                tone_int_reg[i] <= psg_pkg::IV_IDLE;
                tone_cnt_reg[i] <= '0;
                tone_en_reg[i]  <= 1'b0;
                noise_en_reg[i] <= 1'b0;
                tone_out_reg[i] <= 1'b0;
            end
            for (int c = 0; c < psg_pkg::NUM_CHIPS; c++) begin
                noise_int_reg[c] <= psg_pkg::IV_IDLE;
                noise_cnt_reg[c] <= '0;
                lfsr_reg[c]      <= psg_pkg::LFSR_SEED;
                noise_bit_reg[c] <= 1'b0;
                env_int_reg[c]   <= psg_pkg::ENV_IDLE;
                env_cnt_reg[c]   <= '0;
                env_lvl_reg[c]   <= '0;
            end
            clk_sel_reg <= 1'b0;
            kind_reg    <= psg_pkg::PER_TONE;
            chip_reg    <= '0;
            ch_reg      <= '0;
            t_reg       <= '0;
        end else begin
            case (state_reg)
                psg_pkg::ST_IDLE: begin
                    op_reg   <= s_operation;
                    addr_reg <= s_reg_address;
                    data_reg <= s_reg_data;
                    chip_reg <= '0;
                    ch_reg   <= '0;
                    t_reg    <= '0;
                    sum_reg  <= '0;
                end
                psg_pkg::ST_WR_REG: begin
                    if (chip_ok) begin
                        kind_reg <= (reg_idx == psg_pkg::REG_NOISE) ? psg_pkg::PER_NOISE :
                                    (reg_idx >= psg_pkg::REG_ENV_LO) ? psg_pkg::PER_ENV :
                                                                       psg_pkg::PER_TONE;
                        case (reg_idx)
                            psg_pkg::REG_MIXER: begin
                                reg_file_reg[addr_reg[psg_pkg::RF_W-1:0]] <= data_reg;
                                for (int k = 0; k < 3; k++) begin
                                    tone_en_reg[wr_base + psg_pkg::CH_W'(k)]  <= !data_reg[k];
                                    noise_en_reg[wr_base + psg_pkg::CH_W'(k)] <= !data_reg[k+3];
                                end
                            end
                            psg_pkg::REG_ENV_SHAPE: begin
                                reg_file_reg[addr_reg[psg_pkg::RF_W-1:0]] <= data_reg;
                                env_cnt_reg[chip] <= '0;
                            end
                            psg_pkg::REG_SOFT_RESET: begin
                                reg_file_reg[addr_reg[psg_pkg::RF_W-1:0]] <= data_reg;
                                for (int i = 0; i < 15; i++) begin
                                    reg_file_reg[{chip, 4'(i)}] <=
                                        (4'(i) == psg_pkg::REG_MIXER) ? 8'hff : 8'h00;
                                end
                                noise_int_reg[chip] <= psg_pkg::IV_IDLE;
                                env_int_reg[chip]   <= psg_pkg::ENV_IDLE;
                                for (int k = 0; k < 3; k++) begin
                                    tone_int_reg[wr_base + psg_pkg::CH_W'(k)] <= psg_pkg::IV_IDLE;
                                    tone_en_reg[wr_base + psg_pkg::CH_W'(k)]  <= 1'b0;
                                    noise_en_reg[wr_base + psg_pkg::CH_W'(k)] <= 1'b0;
                                end
                                clk_sel_reg <= (chip == '0) ? (data_reg != '0)
                                               : (reg_file_reg[psg_pkg::REG_SOFT_RESET] != '0);
                            end
                            default: begin
                                reg_file_reg[addr_reg[psg_pkg::RF_W-1:0]] <= data_reg;
                            end
                        endcase
                    end
                end
                psg_pkg::ST_WR_PLO: begin
                    p_reg <= (kind_reg == psg_pkg::PER_NOISE) ? {11'b0, rf_rdata[4:0]}
                                                              : {8'b0, rf_rdata};
                end
                psg_pkg::ST_WR_PHI: begin
                    p_reg[15:8] <= (kind_reg == psg_pkg::PER_TONE) ? {4'b0, rf_rdata[3:0]}
                                                                   : rf_rdata;
                end
                psg_pkg::ST_WR_DIV1_WAIT: begin
                    if (div_rsp.done) begin
                        f_reg <= div_f;
                        if (div_f == '0) begin
                            unique case (kind_reg)
                                psg_pkg::PER_TONE:  tone_int_reg[wr_ch] <= psg_pkg::IV_IDLE;
                                psg_pkg::PER_NOISE: noise_int_reg[chip] <= psg_pkg::IV_IDLE;
                                default:            env_int_reg[chip]   <= psg_pkg::ENV_IDLE;
                            endcase
                        end
                    end
                end
                psg_pkg::ST_WR_DIV2_WAIT: begin
                    if (div_rsp.done) begin
                        unique case (kind_reg)
                            psg_pkg::PER_TONE: begin
                                tone_int_reg[wr_ch] <= div_rsp.quotient;
                                tone_cnt_reg[wr_ch] <= '0;
                            end
                            psg_pkg::PER_NOISE: begin
                                noise_int_reg[chip] <= div_rsp.quotient;
                                noise_cnt_reg[chip] <= '0;
                            end
                            default: begin
                                env_int_reg[chip] <= {div_rsp.quotient[26:0], 5'b0};
                            end
                        endcase
                    end
                end
                psg_pkg::ST_TK_NOISE_ADD: begin
                    acc_reg <= noise_cnt_reg[chip_reg] + 32'(step_reg);
                end
                psg_pkg::ST_TK_NOISE_SUB: begin
                    if (sub_gt) begin
                        noise_cnt_reg[chip_reg] <= sub_diff[31:0];
                        lfsr_reg[chip_reg]      <= {lfsr_reg[chip_reg][2] ^ lfsr_reg[chip_reg][0],
                                                    lfsr_reg[chip_reg][16:1]};
                        noise_bit_reg[chip_reg] <= lfsr_reg[chip_reg][1];
                    end else begin
                        noise_cnt_reg[chip_reg] <= acc_reg;
                    end
                    chip_reg <= last_chip ? '0 : chip_reg + 1'b1;
                end
                psg_pkg::ST_TK_ENV_START: begin
                    mode_reg <= rf_rdata[3:0];
                end
                psg_pkg::ST_TK_ENV_APPLY: begin
                    env_lvl_reg[chip_reg] <= env_v;
                    env_cnt_reg[chip_reg] <= env_cnt_new;
                    chip_reg <= last_chip ? '0 : chip_reg + 1'b1;
                end
                psg_pkg::ST_TK_TONE_ADD: begin
                    acc_reg              <= tone_cnt_reg[ch_reg] + 32'(step_reg);
                    tone_cnt_reg[ch_reg] <= tone_cnt_reg[ch_reg] + 32'(step_reg);
                end
                psg_pkg::ST_TK_TONE_CMP: begin
                    if (acc_reg < (tone_int_reg[ch_reg] >> 1)) begin
                        tone_out_reg[ch_reg] <= tone_en_reg[ch_reg];
                    end else if (sub_gt) begin
                        tone_cnt_reg[ch_reg] <= sub_diff[31:0];
                        tone_out_reg[ch_reg] <= tone_en_reg[ch_reg];
                    end else begin
                        tone_out_reg[ch_reg] <= 1'b0;
                    end
                    ch_reg <= last_ch ? '0 : ch_reg + 1'b1;
                end
                psg_pkg::ST_TK_MIX: begin
                    sum_reg <= sum_reg + psg_pkg::SUM_W'(mix_vol);
                    ch_reg  <= last_ch ? '0 : ch_reg + 1'b1;
                    if (t_reg == 2'd2) begin
                        t_reg    <= '0;
                        chip_reg <= last_chip ? '0 : chip_reg + 1'b1;
                    end else begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;

    a_out_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == psg_pkg::ST_TK_OUT && $past(op_reg)))
        else $error("result word raised outside the end of a sample tick");

    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while still busy");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psg_pkg::ST_WR_REG) |-> (op_reg == psg_pkg::OP_WRITE))
        else $error("register write path entered by a tick word");

    a_out_load_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psg_pkg::ST_TK_OUT && !m_valid_reg) |=> m_valid_reg)
        else $error("finished level not presented");

endmodule
